// ===== hdl/ptma_pkg.sv =====
// Package for the sparse polynomial merge-add block.
// Holds term layout constants, command codes, the sequencer state type
// and the merge step result type. No dependencies.
package ptma_pkg;

    localparam int COEF_W = 16;
    localparam int EXP_W  = 16;
    localparam int TERM_W = COEF_W + EXP_W;
    localparam int SUM_W  = COEF_W + 1;

    localparam logic [1:0] CMD_APPEND_FIRST  = 2'd0;
    localparam logic [1:0] CMD_APPEND_SECOND = 2'd1;
    localparam logic [1:0] CMD_MERGE         = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_STEP,
        ST_OUT
    } t_state;

    // Result of one merge step: which lists advance and the emitted term.
    typedef struct packed {
        logic                    take_a;
        logic                    take_b;
        logic signed [SUM_W-1:0] coef;
        logic signed [EXP_W-1:0] expo;
    } t_step;

endpackage

// ===== hdl/polynomial_term_merge_add.sv =====
// Sparse polynomial addition: two term stores merged by a small sequencer.
// Uses ptma_pkg, ptma_ram for both term stores and ptma_step for the compare and add.
// Sequencing: an append request is done once accepted; a merge goes through a read state, a
// compare/add state and an output state (straight to the output state when both lists are empty),
// then each further term takes a compare/add state and an output state while not stalled.
// Reset (synchronous, active low) returns to idle, empties both lists and clears the overflow flag.
module polynomial_term_merge_add #(
    parameter int TERMS_PER_LIST = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Request channel.
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [1:0]                          i_command,
    input  logic signed [ptma_pkg::COEF_W-1:0]  i_term_coef,
    input  logic signed [ptma_pkg::EXP_W-1:0]   i_term_exp,
    // Result channel.
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [ptma_pkg::SUM_W-1:0]   o_sum_coef,
    output logic signed [ptma_pkg::EXP_W-1:0]   o_sum_exp,
    output logic                                o_last_term,
    output logic                                o_empty_sum,
    output logic                                o_term_dropped
);
    import ptma_pkg::*;

    localparam int CW = $clog2(TERMS_PER_LIST + 1);
    localparam int IW = (TERMS_PER_LIST > 1) ? $clog2(TERMS_PER_LIST) : 1;
    localparam logic [CW-1:0] FULL = CW'(TERMS_PER_LIST);

    t_state r_state, n_state;

    // Fill counts of the two stores and the read pointers used while merging.
    logic [CW-1:0] r_cnt_a, n_cnt_a;
    logic [CW-1:0] r_cnt_b, n_cnt_b;
    logic [CW-1:0] r_ptr_a, n_ptr_a;
    logic [CW-1:0] r_ptr_b, n_ptr_b;
    logic          r_overflow, n_overflow;

    // Output register; r_final marks the result that ends the merge.
    logic signed [SUM_W-1:0] r_sum_coef, n_sum_coef;
    logic signed [EXP_W-1:0] r_sum_exp, n_sum_exp;
    logic                    r_last, n_last;
    logic                    r_empty, n_empty;
    logic                    r_dropped, n_dropped;
    logic                    r_final, n_final;

    logic            req_take;
    logic            out_take;
    logic            is_merge;
    logic            both_empty;
    logic            we_a;
    logic            we_b;
    logic [TERM_W-1:0] wr_word;
    logic [TERM_W-1:0] rd_word_a;
    logic [TERM_W-1:0] rd_word_b;
    t_step           step;
    logic [CW-1:0]   step_ptr_a;
    logic [CW-1:0]   step_ptr_b;

    assign req_take   = i_valid && !o_stall;
    assign out_take   = o_valid && !i_stall;
    assign is_merge   = req_take && (i_command == CMD_MERGE);
    assign both_empty = (r_cnt_a == '0) && (r_cnt_b == '0);
    assign wr_word    = {i_term_exp, i_term_coef};
    assign we_a = req_take && (i_command == CMD_APPEND_FIRST) && (r_cnt_a < FULL);
    assign we_b = req_take && (i_command == CMD_APPEND_SECOND) && (r_cnt_b < FULL);

    // The read address is the merge pointer; each store is written at its fill count.
    ptma_ram #(.WIDTH(TERM_W), .DEPTH(TERMS_PER_LIST)) u_store_a (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (r_cnt_a[IW-1:0]),
        .i_wdata (wr_word),
        .i_raddr (r_ptr_a[IW-1:0]),
        .o_rdata (rd_word_a)
    );

    ptma_ram #(.WIDTH(TERM_W), .DEPTH(TERMS_PER_LIST)) u_store_b (
        .i_clk   (i_clk),
        .i_we    (we_b),
        .i_waddr (r_cnt_b[IW-1:0]),
        .i_wdata (wr_word),
        .i_raddr (r_ptr_b[IW-1:0]),
        .o_rdata (rd_word_b)
    );

    ptma_step u_step (
        .i_word_a (rd_word_a),
        .i_word_b (rd_word_b),
        .i_has_a  (r_ptr_a < r_cnt_a),
        .i_has_b  (r_ptr_b < r_cnt_b),
        .o_step   (step)
    );

    assign step_ptr_a = r_ptr_a + CW'(step.take_a);
    assign step_ptr_b = r_ptr_b + CW'(step.take_b);

    // Next state. The pointers stay put in the output state, so the RAM read
    // issued there already holds the next head terms when the result leaves.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (is_merge) begin
                    n_state = both_empty ? ST_OUT : ST_READ;
                end
            end
            ST_READ: n_state = ST_STEP;
            ST_STEP: n_state = ST_OUT;
            ST_OUT: begin
                if (out_take) begin
                    n_state = r_final ? ST_IDLE : ST_STEP;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Handshake outputs follow the state only.
    always_comb begin
        o_stall = (r_state != ST_IDLE);
        o_valid = (r_state == ST_OUT);
    end

    // Datapath next values.
    always_comb begin
        n_cnt_a    = r_cnt_a;
        n_cnt_b    = r_cnt_b;
        n_ptr_a    = r_ptr_a;
        n_ptr_b    = r_ptr_b;
        n_overflow = r_overflow;
        n_sum_coef = r_sum_coef;
        n_sum_exp  = r_sum_exp;
        n_last     = r_last;
        n_empty    = r_empty;
        n_dropped  = r_dropped;
        n_final    = r_final;
        case (r_state)
            ST_IDLE: begin
                if (req_take) begin
                    case (i_command)
                        CMD_APPEND_FIRST: begin
                            if (we_a) begin
                                n_cnt_a = r_cnt_a + CW'(1);
                            end else begin
                                n_overflow = 1'b1;
                            end
                        end
                        CMD_APPEND_SECOND: begin
                            if (we_b) begin
                                n_cnt_b = r_cnt_b + CW'(1);
                            end else begin
                                n_overflow = 1'b1;
                            end
                        end
                        CMD_MERGE: begin
                            n_ptr_a   = '0;
                            n_ptr_b   = '0;
                            n_dropped = r_overflow;
                            // Two empty lists give a single flagged result.
                            n_sum_coef = '0;
                            n_sum_exp  = '0;
                            n_last     = 1'b0;
                            n_empty    = both_empty;
                            n_final    = both_empty;
                        end
                        default: ;
                    endcase
                end
            end
            ST_STEP: begin
                n_sum_coef = step.coef;
                n_sum_exp  = step.expo;
                n_ptr_a    = step_ptr_a;
                n_ptr_b    = step_ptr_b;
                n_empty    = 1'b0;
                n_last     = (step_ptr_a >= r_cnt_a) && (step_ptr_b >= r_cnt_b);
                n_final    = n_last;
            end
            ST_OUT: begin
                // Both stores are emptied once the closing result is taken.
                if (out_take && r_final) begin
                    n_cnt_a    = '0;
                    n_cnt_b    = '0;
                    n_overflow = 1'b0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_cnt_a    <= '0;
            r_cnt_b    <= '0;
            r_overflow <= 1'b0;
            r_final    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cnt_a    <= n_cnt_a;
            r_cnt_b    <= n_cnt_b;
            r_overflow <= n_overflow;
            r_final    <= n_final;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr_a    <= n_ptr_a;
        r_ptr_b    <= n_ptr_b;
        r_sum_coef <= n_sum_coef;
        r_sum_exp  <= n_sum_exp;
        r_last     <= n_last;
        r_empty    <= n_empty;
        r_dropped  <= n_dropped;
    end

    assign o_sum_coef     = r_sum_coef;
    assign o_sum_exp      = r_sum_exp;
    assign o_last_term    = r_last;
    assign o_empty_sum    = r_empty;
    assign o_term_dropped = r_dropped;

endmodule

// ===== hdl/ptma_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Used for both term stores; no package dependency.
module ptma_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/ptma_step.sv =====
// Combinational compare and add unit for one merge step.
// Compares the head exponents of both lists and forms the emitted term.
// Depends on ptma_pkg.
module ptma_step (
    input  logic [ptma_pkg::TERM_W-1:0] i_word_a,
    input  logic [ptma_pkg::TERM_W-1:0] i_word_b,
    input  logic                        i_has_a,
    input  logic                        i_has_b,
    output ptma_pkg::t_step             o_step
);
    import ptma_pkg::*;

    logic signed [COEF_W-1:0] coef_a;
    logic signed [COEF_W-1:0] coef_b;
    logic signed [EXP_W-1:0]  exp_a;
    logic signed [EXP_W-1:0]  exp_b;

    assign coef_a = $signed(i_word_a[COEF_W-1:0]);
    assign coef_b = $signed(i_word_b[COEF_W-1:0]);
    assign exp_a  = $signed(i_word_a[TERM_W-1:COEF_W]);
    assign exp_b  = $signed(i_word_b[TERM_W-1:COEF_W]);

    always_comb begin
        o_step = '0;
        if (i_has_a && i_has_b) begin
            if (exp_a > exp_b) begin
                o_step.take_a = 1'b1;
                o_step.coef   = SUM_W'(coef_a);
                o_step.expo   = exp_a;
            end else if (exp_a == exp_b) begin
                o_step.take_a = 1'b1;
                o_step.take_b = 1'b1;
                o_step.coef   = SUM_W'(coef_a) + SUM_W'(coef_b);
                o_step.expo   = exp_a;
            end else begin
                o_step.take_b = 1'b1;
                o_step.coef   = SUM_W'(coef_b);
                o_step.expo   = exp_b;
            end
        end else if (i_has_a) begin
            o_step.take_a = 1'b1;
            o_step.coef   = SUM_W'(coef_a);
            o_step.expo   = exp_a;
        end else begin
            o_step.take_b = 1'b1;
            o_step.coef   = SUM_W'(coef_b);
            o_step.expo   = exp_b;
        end
    end

endmodule
